// ===== sv/cvt_pkg.sv =====
// Shared types, register codes and saturation helpers for the clip-to-viewport transform.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cvt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int PROJ_STAGES   = 5;
   localparam int CSR_IDX_W     = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_ORG   = 3'd5;

   localparam logic signed [31:0] DEPTH_RESET = 32'sd32768;

   localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
   localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

   typedef struct packed {
      logic signed [31:0] clip_x;
      logic signed [31:0] clip_y;
      logic signed [31:0] clip_z;
      logic signed [31:0] clip_w;
      logic [15:0]        vertex_tag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic [16:0]        screen_depth;
      logic signed [31:0] inverse_w;
      logic [15:0]        result_tag;
      logic               overflow;
   } rsp_type;

   // clamped coordinates riding alongside the reciprocal
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [15:0]        tag;
   } side_type;

   typedef struct packed {
      logic               ov;
      logic signed [31:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [64:0] v);
      sat_type r;
      if (v > SAT_MAX) begin
         r.ov  = 1'b1;
         r.val = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r.ov  = 1'b1;
         r.val = 32'sh80000000;
      end else begin
         r.ov  = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

   // clamp to at least -w, then to at most w
   function automatic logic signed [31:0] clamp_w(input logic signed [31:0] c,
                                                  input logic signed [31:0] w);
      logic signed [32:0] cc;
      logic signed [32:0] ww;
      ww = {w[31], w};
      cc = {c[31], c};
      if (cc < -ww) cc = -ww;
      if (cc > ww) cc = ww;
      return cc[31:0];
   endfunction

endpackage

// ===== sv/cvt_recip.sv =====
// Pipelined restoring divider forming 2^(2F)/w, one quotient bit per stage.
// Depends on cvt_pkg.
`timescale 1ns / 1ps
module cvt_recip #(
   parameter int FRAC_BITS = cvt_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  logic signed [31:0] in_w,
   input  cvt_pkg::side_type  in_side,
   output logic               out_vld,
   output logic signed [31:0] out_inv,
   output logic               out_ovf,
   output cvt_pkg::side_type  out_side
);
   import cvt_pkg::*;

   localparam int QW = 2 * FRAC_BITS + 1;
   localparam int RW = 33;

   logic [RW-1:0]   rem_ff  [0:QW-1];
   logic [QW-1:0]   q_ff    [0:QW-1];
   logic [31:0]     div_ff  [0:QW-1];
   logic            neg_ff  [0:QW-1];
   logic            zero_ff [0:QW-1];
   logic            vld_ff  [0:QW-1];
   side_type        side_ff [0:QW-1];

   logic [31:0] mag;
   assign mag = in_w[31] ? (32'd0 - in_w) : in_w;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [RW-1:0] rem_src;
      logic [QW-1:0] q_src;
      logic [31:0]   div_src;
      logic          neg_src;
      logic          zero_src;
      logic          vld_src;
      side_type      side_src;
      logic [RW-1:0] rem_sh;
      logic          ge;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] q_in;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign q_src    = '0;
         assign div_src  = mag;
         assign neg_src  = in_w[31];
         assign zero_src = (in_w == 32'sd0);
         assign vld_src  = in_vld;
         assign side_src = in_side;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign q_src    = q_ff[k-1];
         assign div_src  = div_ff[k-1];
         assign neg_src  = neg_ff[k-1];
         assign zero_src = zero_ff[k-1];
         assign vld_src  = vld_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      // numerator is a single one followed by zeros
      assign rem_sh = {rem_src[RW-2:0], (k == 0) ? 1'b1 : 1'b0};
      assign ge     = rem_sh >= {1'b0, div_src};
      assign rem_in = ge ? (rem_sh - {1'b0, div_src}) : rem_sh;
      assign q_in   = {q_src[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rem_ff[k]  <= rem_in;
         q_ff[k]    <= q_in;
         div_ff[k]  <= div_src;
         neg_ff[k]  <= neg_src;
         zero_ff[k] <= zero_src;
         side_ff[k] <= side_src;
      end
   end

   logic signed [64:0] q_ext;
   logic signed [64:0] q_sgn;
   sat_type            q_sat;
   logic               vld_out_ff;
   logic signed [31:0] inv_out_ff;
   logic               ovf_out_ff;
   side_type           side_out_ff;

   assign q_ext = {{(65-QW){1'b0}}, q_ff[QW-1]};
   assign q_sgn = neg_ff[QW-1] ? -q_ext : q_ext;
   assign q_sat = sat32(q_sgn);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out_ff <= 1'b0;
      end else begin
         vld_out_ff <= vld_ff[QW-1];
      end
      // zero w: force a zero reciprocal, no overflow
      inv_out_ff  <= zero_ff[QW-1] ? 32'sd0 : q_sat.val;
      ovf_out_ff  <= zero_ff[QW-1] ? 1'b0 : q_sat.ov;
      side_out_ff <= side_ff[QW-1];
   end

   assign out_vld  = vld_out_ff;
   assign out_inv  = inv_out_ff;
   assign out_ovf  = ovf_out_ff;
   assign out_side = side_out_ff;

endmodule

// ===== sv/cvt_proj.sv =====
// One projection lane: ((inv*c)>>F)*scale>>F + origin, saturating, five stages.
// Depends on cvt_pkg.
`timescale 1ns / 1ps
module cvt_proj #(
   parameter int FRAC_BITS = cvt_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic signed [31:0] in_inv,
   input  logic signed [31:0] in_coord,
   input  logic signed [31:0] in_scale,
   input  logic signed [31:0] in_org,
   output logic signed [31:0] out_val,
   output logic               out_ovf
);
   import cvt_pkg::*;

   logic signed [63:0] m1_ff;
   logic signed [31:0] p1_ff;
   logic               ov1_ff;
   logic signed [63:0] m2_ff;
   logic               ov2_ff;
   logic signed [31:0] p2_ff;
   logic               ov3_ff;
   logic signed [31:0] val_ff;
   logic               ov4_ff;

   logic signed [63:0] s1;
   logic signed [63:0] s2;
   logic signed [32:0] sum;
   sat_type            sat1;
   sat_type            sat2;
   sat_type            sat3;

   assign s1   = m1_ff >>> FRAC_BITS;
   assign sat1 = sat32({s1[63], s1});
   assign s2   = m2_ff >>> FRAC_BITS;
   assign sat2 = sat32({s2[63], s2});
   assign sum  = {p2_ff[31], p2_ff} + {in_org[31], in_org};
   assign sat3 = sat32({{32{sum[32]}}, sum});

   always_ff @(posedge clock) begin
      m1_ff  <= 64'(in_inv) * 64'(in_coord);
      p1_ff  <= sat1.val;
      ov1_ff <= sat1.ov;
      m2_ff  <= 64'(p1_ff) * 64'(in_scale);
      ov2_ff <= ov1_ff;
      p2_ff  <= sat2.val;
      ov3_ff <= ov2_ff | sat2.ov;
      val_ff <= sat3.val;
      ov4_ff <= ov3_ff | sat3.ov;
   end

   assign out_val = val_ff;
   assign out_ovf = ov4_ff;

endmodule

// ===== sv/clip_to_viewport_transform.sv =====
// Top level of the clip-to-viewport transform: registers, clamp, divider and three lanes.
// Depends on cvt_pkg, cvt_recip and cvt_proj.
`timescale 1ns / 1ps
// One vertex enters per clock and every vertex leaves with rsp_strobe high for one
// cycle; busy is always low. Each vertex passes the clamp stage, the reciprocal
// divider, which resolves one quotient bit per stage over 2*FRAC_BITS+1 stages
// and then registers its result, the five-stage multiply lanes and the output
// register. Results cannot be held off, so take them as they come. Write the
// viewport registers only while no vertex is in flight.
module clip_to_viewport_transform #(
   parameter int FRAC_BITS = cvt_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  cvt_pkg::req_type                  req_payload,
   output logic                              rsp_strobe,
   output cvt_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_we,
   input  logic [cvt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_wdata
);
   import cvt_pkg::*;

   localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

   logic signed [31:0] scale_x_ff, scale_y_ff, org_x_ff, org_y_ff, dscale_ff, dorg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= '0;
         scale_y_ff <= '0;
         org_x_ff   <= '0;
         org_y_ff   <= '0;
         dscale_ff  <= DEPTH_RESET;
         dorg_ff    <= DEPTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SCALE_X:     scale_x_ff <= csr_wdata;
            REG_SCALE_Y:     scale_y_ff <= csr_wdata;
            REG_ORIGIN_X:    org_x_ff   <= csr_wdata;
            REG_ORIGIN_Y:    org_y_ff   <= csr_wdata;
            REG_DEPTH_SCALE: dscale_ff  <= csr_wdata;
            REG_DEPTH_ORG:   dorg_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // clamp stage
   logic               vld_a_ff;
   logic signed [31:0] w_a_ff;
   side_type           side_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else begin
         vld_a_ff <= start & ~busy;
      end
      w_a_ff        <= req_payload.clip_w;
      side_a_ff.x   <= clamp_w(req_payload.clip_x, req_payload.clip_w);
      side_a_ff.y   <= clamp_w(req_payload.clip_y, req_payload.clip_w);
      side_a_ff.z   <= clamp_w(req_payload.clip_z, req_payload.clip_w);
      side_a_ff.tag <= req_payload.vertex_tag;
   end

   logic               r_vld;
   logic signed [31:0] r_inv;
   logic               r_ovf;
   side_type           r_side;

   cvt_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld_a_ff),
      .in_w     (w_a_ff),
      .in_side  (side_a_ff),
      .out_vld  (r_vld),
      .out_inv  (r_inv),
      .out_ovf  (r_ovf),
      .out_side (r_side)
   );

   logic signed [31:0] sx, sy, sd;
   logic               ovx, ovy, ovd;

   cvt_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_x (
      .clock(clock), .in_inv(r_inv), .in_coord(r_side.x),
      .in_scale(scale_x_ff), .in_org(org_x_ff), .out_val(sx), .out_ovf(ovx)
   );
   cvt_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_y (
      .clock(clock), .in_inv(r_inv), .in_coord(r_side.y),
      .in_scale(scale_y_ff), .in_org(org_y_ff), .out_val(sy), .out_ovf(ovy)
   );
   cvt_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_z (
      .clock(clock), .in_inv(r_inv), .in_coord(r_side.z),
      .in_scale(dscale_ff), .in_org(dorg_ff), .out_val(sd), .out_ovf(ovd)
   );

   // carry valid, tag, reciprocal and its overflow flag alongside the lanes
   logic               dly_vld_ff [0:PROJ_STAGES-1];
   logic signed [31:0] dly_inv_ff [0:PROJ_STAGES-1];
   logic               dly_ovf_ff [0:PROJ_STAGES-1];
   logic [15:0]        dly_tag_ff [0:PROJ_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff[0] <= 1'b0;
      end else begin
         dly_vld_ff[0] <= r_vld;
      end
      dly_inv_ff[0] <= r_inv;
      dly_ovf_ff[0] <= r_ovf;
      dly_tag_ff[0] <= r_side.tag;
   end

   for (genvar k = 1; k < PROJ_STAGES; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            dly_vld_ff[k] <= 1'b0;
         end else begin
            dly_vld_ff[k] <= dly_vld_ff[k-1];
         end
         dly_inv_ff[k] <= dly_inv_ff[k-1];
         dly_ovf_ff[k] <= dly_ovf_ff[k-1];
         dly_tag_ff[k] <= dly_tag_ff[k-1];
      end
   end

   logic signed [32:0] depth_ext;
   logic signed [32:0] depth_clamped;
   logic               strobe_ff;
   rsp_type            rsp_ff;

   always_comb begin
      depth_ext     = {sd[31], sd};
      depth_clamped = depth_ext;
      if (depth_ext < 33'sd0) depth_clamped = '0;
      if (depth_ext > ONE) depth_clamped = ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dly_vld_ff[PROJ_STAGES-1];
      end
      rsp_ff.screen_x     <= sx;
      rsp_ff.screen_y     <= sy;
      rsp_ff.screen_depth <= depth_clamped[16:0];
      rsp_ff.inverse_w    <= dly_inv_ff[PROJ_STAGES-1];
      rsp_ff.result_tag   <= dly_tag_ff[PROJ_STAGES-1];
      rsp_ff.overflow     <= dly_ovf_ff[PROJ_STAGES-1] | ovx | ovy | ovd;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/cvt_checker.sv =====
// Port-level checks on the clip-to-viewport transform, bound to the top level.
// Depends on cvt_pkg and clip_to_viewport_transform.
`timescale 1ns / 1ps
module cvt_checker #(
   parameter int FRAC_BITS = cvt_pkg::FRAC_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input cvt_pkg::req_type              req_payload,
   input logic                          rsp_strobe,
   input cvt_pkg::rsp_type              rsp_payload
);
   import cvt_pkg::*;

   localparam int LATENCY = 2 * FRAC_BITS + 9;

   // every transaction comes out after the fixed latency
   a_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted transaction did not emerge");

   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transaction");

   a_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_payload.result_tag == $past(req_payload.vertex_tag, LATENCY))
      else $error("tag out of order");

   // a zero reciprocal cannot saturate anything downstream
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.inverse_w == 32'sd0) |-> !rsp_payload.overflow)
      else $error("overflow with zero reciprocal");

endmodule

bind clip_to_viewport_transform cvt_checker #(.FRAC_BITS(FRAC_BITS)) u_cvt_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
